### design/assert_macros.svh
// Assertion macros used by the top-level design file.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define SLRU_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define SLRU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/slru_pkg.sv
// Package for the set-associative LRU cache tag model.
// Holds field widths, codes and the control structs shared by the design files.
package slru_pkg;

  localparam int ADDR_W     = 32;
  localparam int REQ_W      = 2;
  localparam int OUTCOME_W  = 2;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int DEF_MAX_SET_BITS = 4;
  localparam int DEF_MAX_WAYS     = 4;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  typedef struct packed {
    logic start;
    logic step;
  } slru_scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic inv;
  } slru_scan_flags_t;

  typedef struct packed {
    logic rd_en;
    logic tag_we;
    logic state_we;
  } slru_mem_ctl_t;

endpackage

### design/slru_if.sv
// Valid/ready channel interfaces for the request, result and configuration ports.
// Depends on slru_pkg for the payload widths.
interface slru_in_if import slru_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ADDR_W-1:0]  address;

  modport source (output valid, output req_type, output address, input ready);
  modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface slru_out_if import slru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic                 extra_hit;
  logic [TOTAL_W-1:0]   hit_total;
  logic [TOTAL_W-1:0]   miss_total;
  logic [TOTAL_W-1:0]   evict_total;

  modport source (output valid, output outcome, output extra_hit, output hit_total,
                  output miss_total, output evict_total, input ready);
  modport sink   (input valid, input outcome, input extra_hit, input hit_total,
                  input miss_total, input evict_total, output ready);
endinterface

interface slru_cfg_if import slru_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/slru_set_store.sv
// Per-set line storage: one row of tags and one row of valid/rank entries per set.
// Depends on slru_pkg; both memories have one write port and a registered read port.
module slru_set_store import slru_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
  input  logic                                   clk,
  input  slru_mem_ctl_t                          ctl,
  input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] rd_set,
  input  logic [((MAX_SET_BITS > 0) ? MAX_SET_BITS : 1)-1:0] wr_set,
  input  logic [MAX_WAYS*ADDR_W-1:0]             wr_tag_row,
  input  logic [MAX_WAYS*(((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)+1)-1:0] wr_state_row,
  output logic [MAX_WAYS*ADDR_W-1:0]             rd_tag_row,
  output logic [MAX_WAYS*(((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)+1)-1:0] rd_state_row
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int STATE_W  = MAX_WAYS * (RANK_W + 1);

  logic [MAX_WAYS*ADDR_W-1:0] tag_mem   [NUM_SETS];
  logic [STATE_W-1:0]         state_mem [NUM_SETS];

  always_ff @(posedge clk) begin
    if (ctl.tag_we) begin
      tag_mem[wr_set] <= wr_tag_row;
    end
    if (ctl.rd_en) begin
      rd_tag_row <= tag_mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.state_we) begin
      state_mem[wr_set] <= wr_state_row;
    end
    if (ctl.rd_en) begin
      rd_state_row <= state_mem[rd_set];
    end
  end

endmodule

### design/slru_way_scan.sv
// Shared compare unit that walks the ways of one set, one way per cycle.
// Depends on slru_pkg; tracks first hit, first empty way and the LRU victim.
module slru_way_scan import slru_pkg::*; #(
  parameter int MAX_WAYS = DEF_MAX_WAYS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  slru_scan_ctl_t                         ctl,
  input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] way,
  input  logic [MAX_WAYS*ADDR_W-1:0]             tag_row,
  input  logic [MAX_WAYS*(((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)+1)-1:0] state_row,
  input  logic [ADDR_W-1:0]                      ref_tag,
  output slru_scan_flags_t                       flags,
  output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] hit_way,
  output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] inv_way,
  output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] vic_way
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int ENT_W  = RANK_W + 1;

  logic [ADDR_W-1:0] sel_tag;
  logic              sel_valid;
  logic [RANK_W-1:0] sel_rank;

  slru_scan_flags_t  flags_r;
  logic [WAY_W-1:0]  hit_way_r, inv_way_r, vic_way_r;
  logic [RANK_W-1:0] vic_rank_r;

  assign sel_tag   = tag_row[way*ADDR_W +: ADDR_W];
  assign sel_valid = state_row[way*ENT_W + RANK_W];
  assign sel_rank  = state_row[way*ENT_W +: RANK_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      hit_way_r  <= '0;
      inv_way_r  <= '0;
      vic_way_r  <= '0;
      vic_rank_r <= '0;
    end else if (ctl.start) begin
      flags_r    <= '0;
      vic_way_r  <= '0;
      vic_rank_r <= '0;
    end else if (ctl.step) begin
      if (sel_valid && (sel_tag == ref_tag) && !flags_r.hit) begin
        flags_r.hit <= 1'b1;
        hit_way_r   <= way;
      end
      if (!sel_valid && !flags_r.inv) begin
        flags_r.inv <= 1'b1;
        inv_way_r   <= way;
      end
      // Strict compare keeps the first way among equal oldest ranks.
      if (sel_rank > vic_rank_r) begin
        vic_way_r  <= way;
        vic_rank_r <= sel_rank;
      end
    end
  end

  assign flags   = flags_r;
  assign hit_way = hit_way_r;
  assign inv_way = inv_way_r;
  assign vic_way = vic_way_r;

endmodule

### design/set_assoc_lru_cache_tag_model.sv
// Channel  | Dir | Payload                                   | Transaction when
// in_ch    | in  | req_type, address                         | valid && ready
// out_ch   | out | outcome, extra_hit, hit/miss/evict totals | valid && ready
// cfg_ch   | in  | index, data                               | valid (ready held high)
// An access splits the address and reads the set when it is accepted, steps through
// each way in use on the shared compare unit, and then writes the set back.
// After reset a clearing pass zeroes the valid/rank row of every set;
// requests wait during it, configuration writes are taken at any time.
// A finished result sits in the output register; the write-back of the next access
// stalls until that result is taken. Reset is synchronous and active low.
// Depends on slru_pkg, slru_if, slru_set_store, slru_way_scan and assert_macros.svh.
`include "assert_macros.svh"

module set_assoc_lru_cache_tag_model import slru_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS
) (
  input  logic      clk,
  input  logic      rst_n,
  slru_in_if.sink   in_ch,
  slru_out_if.source out_ch,
  slru_cfg_if.sink  cfg_ch
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int RANK_W   = WAY_W;
  localparam int ENT_W    = RANK_W + 1;
  localparam int STATE_W  = MAX_WAYS * ENT_W;
  localparam int TROW_W   = MAX_WAYS * ADDR_W;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [SET_W-1:0]    clr_set_r;
  logic [SET_W-1:0]    set_r, set_nxt;
  logic [ADDR_W-1:0]   tag_r, tag_nxt;
  logic                is_modify_r;
  logic [WAY_W-1:0]    way_r;
  logic [2:0]          set_bits_r;
  logic [4:0]          block_bits_r;
  logic [2:0]          ways_r;
  logic [TOTAL_W-1:0]  hits_r, hits_nxt;
  logic [TOTAL_W-1:0]  misses_r, misses_nxt;
  logic [TOTAL_W-1:0]  evicts_r, evicts_nxt;
  logic                out_valid_r;
  logic [OUTCOME_W-1:0] outcome_r, outcome_nxt;
  logic                extra_hit_r;

  logic                in_acc, upd_fire, way_last, clr_last;
  logic [2:0]          s_eff;
  logic [WCNT_W-1:0]   ways_eff;
  logic [ADDR_W-1:0]   shifted, set_full;
  logic [5:0]          tag_shift;

  slru_mem_ctl_t       mem_ctl;
  slru_scan_ctl_t      scan_ctl;
  slru_scan_flags_t    flags;
  logic [WAY_W-1:0]    hit_way, inv_way, vic_way, chosen;
  logic [SET_W-1:0]    wr_set;
  logic [TROW_W-1:0]   rd_tag_row, new_tag_row;
  logic [STATE_W-1:0]  rd_state_row, new_state_row, wr_state_row;
  logic                old_v;
  logic [RANK_W-1:0]   old_rk;
  logic [1:0]          hit_add;
  logic [TOTAL_W:0]    hit_sum;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign upd_fire     = (state_r == ST_UPDATE) && (!out_valid_r || out_ch.ready);
  assign clr_last     = (clr_set_r == SET_W'(NUM_SETS - 1));

  // Effective set bits and ways in use after clamping to the built limits; zero ways counts as one.
  assign s_eff = (int'(set_bits_r) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_r;
  always_comb begin
    if (ways_r == 3'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_r);
    end
  end

  assign shifted   = in_ch.address >> block_bits_r;
  assign set_full  = shifted & ((ADDR_W'(1) << s_eff) - ADDR_W'(1));
  assign set_nxt   = set_full[SET_W-1:0];
  assign tag_shift = 6'(block_bits_r) + 6'(s_eff);
  assign tag_nxt   = in_ch.address >> tag_shift;
  assign way_last  = ((WCNT_W'(way_r) + WCNT_W'(1)) == ways_eff);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN:   if (way_last) state_nxt = ST_UPDATE;
      ST_UPDATE: if (upd_fire) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_set_r <= '0;
      way_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_set_r <= clr_set_r + SET_W'(1);
      end
      if (in_acc) begin
        way_r <= '0;
      end else if (state_r == ST_SCAN && !way_last) begin
        way_r <= way_r + WAY_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r       <= set_nxt;
      tag_r       <= tag_nxt;
      is_modify_r <= (in_ch.req_type == REQ_MODIFY);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd0;
      block_bits_r <= 5'd0;
      ways_r       <= 3'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SET_BITS:    set_bits_r   <= cfg_ch.data[2:0];
        CFG_BLOCK_BITS:  block_bits_r <= cfg_ch.data[4:0];
        CFG_WAYS_IN_USE: ways_r       <= cfg_ch.data[2:0];
        default:         ;
      endcase
    end
  end

  assign scan_ctl.start = in_acc;
  assign scan_ctl.step  = (state_r == ST_SCAN);

  slru_way_scan #(
    .MAX_WAYS (MAX_WAYS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .way       (way_r),
    .tag_row   (rd_tag_row),
    .state_row (rd_state_row),
    .ref_tag   (tag_r),
    .flags     (flags),
    .hit_way   (hit_way),
    .inv_way   (inv_way),
    .vic_way   (vic_way)
  );

  assign chosen = flags.hit ? hit_way : (flags.inv ? inv_way : vic_way);
  assign old_v  = rd_state_row[chosen*ENT_W + RANK_W];
  assign old_rk = rd_state_row[chosen*ENT_W +: RANK_W];

  // Age each valid in-use way younger than the touched way, or all of them on a fill.
  always_comb begin
    new_tag_row   = rd_tag_row;
    new_state_row = rd_state_row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == chosen) begin
        new_state_row[i*ENT_W +: ENT_W]  = {1'b1, {RANK_W{1'b0}}};
        new_tag_row[i*ADDR_W +: ADDR_W] = tag_r;
      end else if ((WCNT_W'(i) < ways_eff) && rd_state_row[i*ENT_W + RANK_W] &&
                   (!old_v || (rd_state_row[i*ENT_W +: RANK_W] < old_rk)) &&
                   (rd_state_row[i*ENT_W +: RANK_W] < RANK_W'(MAX_WAYS - 1))) begin
        new_state_row[i*ENT_W +: RANK_W] = rd_state_row[i*ENT_W +: RANK_W] + RANK_W'(1);
      end
    end
  end

  assign mem_ctl.rd_en    = in_acc;
  assign mem_ctl.tag_we   = upd_fire;
  assign mem_ctl.state_we = upd_fire || (state_r == ST_CLEAR);
  assign wr_set           = (state_r == ST_CLEAR) ? clr_set_r : set_r;
  assign wr_state_row     = (state_r == ST_CLEAR) ? '0 : new_state_row;

  slru_set_store #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_store (
    .clk          (clk),
    .ctl          (mem_ctl),
    .rd_set       (set_nxt),
    .wr_set       (wr_set),
    .wr_tag_row   (new_tag_row),
    .wr_state_row (wr_state_row),
    .rd_tag_row   (rd_tag_row),
    .rd_state_row (rd_state_row)
  );

  // A modify can add two hits in one access; the sum saturates once.
  assign hit_add    = {1'b0, flags.hit} + {1'b0, is_modify_r};
  assign hit_sum    = {1'b0, hits_r} + (TOTAL_W + 1)'(hit_add);
  assign hits_nxt   = hit_sum[TOTAL_W] ? '1 : hit_sum[TOTAL_W-1:0];
  assign misses_nxt = (flags.hit || (&misses_r)) ? misses_r : misses_r + TOTAL_W'(1);
  assign evicts_nxt = (flags.hit || flags.inv || (&evicts_r)) ? evicts_r :
                      evicts_r + TOTAL_W'(1);
  assign outcome_nxt = flags.hit ? OUTCOME_HIT : (flags.inv ? OUTCOME_FILL : OUTCOME_EVICT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (upd_fire) begin
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      evicts_r    <= evicts_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      outcome_r   <= outcome_nxt;
      extra_hit_r <= is_modify_r;
    end
  end

  // Totals only move at write-back, which waits for the output register to empty.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.outcome     = outcome_r;
  assign out_ch.extra_hit   = extra_hit_r;
  assign out_ch.hit_total   = hits_r;
  assign out_ch.miss_total  = misses_r;
  assign out_ch.evict_total = evicts_r;

  `SLRU_ASSERT_RST(a_evict_le_miss, clk, rst_n, evicts_r <= misses_r, "evictions exceed misses")
  `SLRU_ASSERT_RST(a_one_in_flight, clk, rst_n, in_acc |=> !in_ch.ready, "second request taken")
  `SLRU_ASSERT_RST(a_out_from_update, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_UPDATE), "result without write-back")
  `SLRU_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (state_r == ST_CLEAR), "reset did not start clearing")

endmodule
